FILE: hw/rtl/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Shared constants, register codes and controller/datapath types of the
// bezier path stepper.
// ----------------------------------------------------------------------------
package bps_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 8;
   localparam int STEP_BITS      = 16;
   localparam int REG_BITS       = 32;
   localparam int OUT_BITS       = 24;
   localparam int CSR_IDX_BITS   = 3;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_START    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_CTRL_ONE = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_CTRL_TWO = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_END      = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_CUBIC    = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_TOTAL    = 3'd5;

   // register reset values
   localparam logic [REG_BITS-1:0]  START_RST    = 32'd0;
   localparam logic [REG_BITS-1:0]  CTRL_ONE_RST = 32'd200;
   localparam logic [REG_BITS-1:0]  CTRL_TWO_RST = 32'd400;
   localparam logic [REG_BITS-1:0]  END_RST      = 32'd0;
   localparam logic                 CUBIC_RST    = 1'b0;
   localparam logic [STEP_BITS-1:0] TOTAL_RST    = 16'd256;

   localparam logic signed [OUT_BITS-1:0] OUT_MAX = 24'sh7FFFFF;
   localparam logic signed [OUT_BITS-1:0] OUT_MIN = 24'sh800000;

   typedef struct packed {
      logic load;   // new item: load points, advance counter
      logic mul;    // form (b - a) * count
      logic prep;   // take magnitude, set up division
      logic div;    // two quotient bits
      logic wb;     // round, shift work queue, append result
      logic drop;   // shift work queue only
      logic emit;   // saturate into output register
   } bps_cmd_type;

   typedef struct packed {
      logic cubic;
   } bps_sts_type;

endpackage

FILE: hw/rtl/bps_if.sv
// ----------------------------------------------------------------------------
// bps channel interfaces
// Request channel (restart flag) and response channel (point and index).
// ----------------------------------------------------------------------------
interface bps_req_if import bps_pkg::*; ();
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface bps_rsp_if import bps_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [OUT_BITS-1:0]  point_x;
   logic signed [OUT_BITS-1:0]  point_y;
   logic        [STEP_BITS-1:0] step_index;

   modport source (output valid, output point_x, output point_y, output step_index,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input step_index,
                   output ready);
endinterface

FILE: hw/rtl/bps_lane.sv
// ----------------------------------------------------------------------------
// bps_lane
// One coordinate of an interpolation a + round((b - a) * c / n): a multiply
// step, then a radix-4 restoring divider, then rounding.
// ----------------------------------------------------------------------------
module bps_lane import bps_pkg::*; #(
   parameter int VAL_BITS = COORD_BITS_DEF + FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  bps_cmd_type                cmd,
   input  logic signed [VAL_BITS-1:0] op_a,
   input  logic signed [VAL_BITS-1:0] op_b,
   input  logic [STEP_BITS-1:0]       count,
   input  logic [STEP_BITS-1:0]       total,
   output logic signed [VAL_BITS-1:0] res
);

   localparam int DW  = VAL_BITS + 1;
   localparam int MW  = VAL_BITS + STEP_BITS;
   localparam int QW  = 2 * ((VAL_BITS + 1) / 2);
   localparam int EW  = QW + STEP_BITS;
   localparam int PRW = DW + STEP_BITS + 1;
   localparam int BW  = VAL_BITS + 2;

   logic signed [DW-1:0]  diff;
   logic signed [PRW-1:0] prod;
   logic signed [PRW-1:0] prod_in, prod_ff;
   logic signed [PRW-1:0] prod_abs;
   logic [EW-1:0]         mag_ext;
   logic                  neg_in, neg_ff;
   logic [STEP_BITS-1:0]  rem_in, rem_ff;
   logic [QW-1:0]         quo_in, quo_ff;
   logic [STEP_BITS:0]    s1, s2;
   logic signed [QW:0]    q_ext, qf;
   logic [STEP_BITS-1:0]  rfin;
   logic signed [BW-1:0]  base, sum;
   logic [STEP_BITS:0]    twice;
   logic                  up;

   // one restoring step: {quotient bit, new remainder}
   function automatic logic [STEP_BITS:0] div_bit(input logic [STEP_BITS-1:0] r,
                                                  input logic b,
                                                  input logic [STEP_BITS-1:0] n);
      logic [STEP_BITS:0] t;
      t = {r, b};
      if (t >= {1'b0, n}) begin
         return {1'b1, STEP_BITS'(t - {1'b0, n})};
      end
      return {1'b0, t[STEP_BITS-1:0]};
   endfunction

   assign diff = DW'(op_b) - DW'(op_a);
   assign prod = diff * $signed({1'b0, count});
   assign prod_in = cmd.mul ? prod : prod_ff;

   assign prod_abs = prod_ff[PRW-1] ? -prod_ff : prod_ff;
   assign mag_ext  = EW'(prod_abs[MW-1:0]);

   assign s1 = div_bit(rem_ff, quo_ff[QW-1], total);
   assign s2 = div_bit(s1[STEP_BITS-1:0], quo_ff[QW-2], total);

   always_comb begin
      neg_in = neg_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.prep) begin
         // quotient is below 2^QW, so the top bits alone start below the divisor
         neg_in = prod_ff[PRW-1];
         rem_in = mag_ext[EW-1:QW];
         quo_in = mag_ext[QW-1:0];
      end else if (cmd.div) begin
         rem_in = s2[STEP_BITS-1:0];
         quo_in = {quo_ff[QW-3:0], s1[STEP_BITS], s2[STEP_BITS]};
      end
   end

   // floor quotient and nonnegative remainder, then round half away from zero
   always_comb begin
      q_ext = $signed({1'b0, quo_ff});
      if (!neg_ff) begin
         qf   = q_ext;
         rfin = rem_ff;
      end else if (rem_ff == '0) begin
         qf   = -q_ext;
         rfin = '0;
      end else begin
         qf   = -q_ext - (QW+1)'(1);
         rfin = total - rem_ff;
      end
      base  = BW'(op_a) + BW'(qf);
      twice = {rfin, 1'b0};
      up    = (twice > {1'b0, total}) || ((twice == {1'b0, total}) && !base[BW-1]);
      sum   = base + (up ? BW'(1) : BW'(0));
      res   = (total == '0) ? op_b : sum[VAL_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

endmodule

FILE: hw/rtl/bps_dp.sv
// ----------------------------------------------------------------------------
// bps_dp
// Datapath: configuration registers, step counter, four-entry work queue
// of points, x and y interpolation lanes and the output register.
// ----------------------------------------------------------------------------
module bps_dp import bps_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bps_cmd_type                 cmd,
   output bps_sts_type                 sts,
   input  logic                        req_restart,
   input  logic                        csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]     csr_index,
   input  logic [REG_BITS-1:0]         csr_wdata,
   output logic signed [OUT_BITS-1:0]  point_x,
   output logic signed [OUT_BITS-1:0]  point_y,
   output logic [STEP_BITS-1:0]        step_index
);

   localparam int VW = COORD_BITS + FRAC_BITS;
   localparam int PW = (2 * COORD_BITS > REG_BITS) ? 2 * COORD_BITS : REG_BITS;
   localparam int SW = (VW > OUT_BITS) ? VW : OUT_BITS;
   localparam logic signed [SW-1:0] SAT_HI = SW'(OUT_MAX);
   localparam logic signed [SW-1:0] SAT_LO = SW'(OUT_MIN);

   logic [REG_BITS-1:0]  start_in, start_ff, cp1_in, cp1_ff;
   logic [REG_BITS-1:0]  cp2_in, cp2_ff, end_in, end_ff;
   logic                 cubic_in, cubic_ff;
   logic [STEP_BITS-1:0] total_in, total_ff;
   logic [STEP_BITS-1:0] counter_in, counter_ff, count_base;

   logic signed [VW-1:0] wx_in [4];
   logic signed [VW-1:0] wx_ff [4];
   logic signed [VW-1:0] wy_in [4];
   logic signed [VW-1:0] wy_ff [4];
   logic signed [VW-1:0] res_x, res_y;

   logic signed [OUT_BITS-1:0] out_x_in, out_x_ff, out_y_in, out_y_ff;
   logic [STEP_BITS-1:0]       out_idx_in, out_idx_ff;

   function automatic logic signed [VW-1:0] scale(input logic [COORD_BITS-1:0] f);
      logic signed [VW-1:0] v;
      v = VW'($signed(f));
      return v <<< FRAC_BITS;
   endfunction

   function automatic logic signed [VW-1:0] coord_x(input logic [REG_BITS-1:0] word);
      logic [PW-1:0] e;
      e = PW'(word);
      return scale(e[2*COORD_BITS-1:COORD_BITS]);
   endfunction

   function automatic logic signed [VW-1:0] coord_y(input logic [REG_BITS-1:0] word);
      return scale(word[COORD_BITS-1:0]);
   endfunction

   function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [VW-1:0] v);
      logic signed [SW-1:0] e;
      e = SW'(v);
      if (e > SAT_HI) begin
         return OUT_MAX;
      end
      if (e < SAT_LO) begin
         return OUT_MIN;
      end
      return e[OUT_BITS-1:0];
   endfunction

   // configuration writes
   always_comb begin
      start_in = start_ff;
      cp1_in   = cp1_ff;
      cp2_in   = cp2_ff;
      end_in   = end_ff;
      cubic_in = cubic_ff;
      total_in = total_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_START:    start_in = csr_wdata;
            REG_CTRL_ONE: cp1_in   = csr_wdata;
            REG_CTRL_TWO: cp2_in   = csr_wdata;
            REG_END:      end_in   = csr_wdata;
            REG_CUBIC:    cubic_in = csr_wdata[0];
            REG_TOTAL:    total_in = csr_wdata[STEP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // counter saturates at the total, also when the total was lowered
   assign count_base = req_restart ? '0 : counter_ff;
   always_comb begin
      counter_in = counter_ff;
      if (cmd.load) begin
         counter_in = (count_base < total_ff) ? count_base + 16'd1 : total_ff;
      end
   end

   bps_lane #(.VAL_BITS(VW)) u_lane_x (
      .clock (clock),
      .cmd   (cmd),
      .op_a  (wx_ff[0]),
      .op_b  (wx_ff[1]),
      .count (counter_ff),
      .total (total_ff),
      .res   (res_x)
   );

   bps_lane #(.VAL_BITS(VW)) u_lane_y (
      .clock (clock),
      .cmd   (cmd),
      .op_a  (wy_ff[0]),
      .op_b  (wy_ff[1]),
      .count (counter_ff),
      .total (total_ff),
      .res   (res_y)
   );

   // work queue: always interpolate between the two head entries
   always_comb begin
      wx_in = wx_ff;
      wy_in = wy_ff;
      if (cmd.load) begin
         wx_in[0] = coord_x(start_ff);
         wy_in[0] = coord_y(start_ff);
         wx_in[2] = coord_x(cp2_ff);
         wy_in[2] = coord_y(cp2_ff);
         wx_in[3] = coord_x(end_ff);
         wy_in[3] = coord_y(end_ff);
         // straight line puts the end point next to the start
         wx_in[1] = cubic_ff ? coord_x(cp1_ff) : coord_x(end_ff);
         wy_in[1] = cubic_ff ? coord_y(cp1_ff) : coord_y(end_ff);
      end else if (cmd.wb || cmd.drop) begin
         wx_in[0] = wx_ff[1];
         wy_in[0] = wy_ff[1];
         wx_in[1] = wx_ff[2];
         wy_in[1] = wy_ff[2];
         wx_in[2] = wx_ff[3];
         wy_in[2] = wy_ff[3];
         if (cmd.wb) begin
            wx_in[3] = res_x;
            wy_in[3] = res_y;
         end
      end
   end

   always_comb begin
      out_x_in   = out_x_ff;
      out_y_in   = out_y_ff;
      out_idx_in = out_idx_ff;
      if (cmd.emit) begin
         out_x_in   = sat_out(wx_ff[3]);
         out_y_in   = sat_out(wy_ff[3]);
         out_idx_in = counter_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= START_RST;
         cp1_ff     <= CTRL_ONE_RST;
         cp2_ff     <= CTRL_TWO_RST;
         end_ff     <= END_RST;
         cubic_ff   <= CUBIC_RST;
         total_ff   <= TOTAL_RST;
         counter_ff <= '0;
      end else begin
         start_ff   <= start_in;
         cp1_ff     <= cp1_in;
         cp2_ff     <= cp2_in;
         end_ff     <= end_in;
         cubic_ff   <= cubic_in;
         total_ff   <= total_in;
         counter_ff <= counter_in;
      end
   end

   always_ff @(posedge clock) begin
      wx_ff      <= wx_in;
      wy_ff      <= wy_in;
      out_x_ff   <= out_x_in;
      out_y_ff   <= out_y_in;
      out_idx_ff <= out_idx_in;
   end

   assign sts.cubic  = cubic_ff;
   assign point_x    = out_x_ff;
   assign point_y    = out_y_ff;
   assign step_index = out_idx_ff;

endmodule

FILE: hw/rtl/bps_ctrl.sv
// ----------------------------------------------------------------------------
// bps_ctrl
// Controller: sequences load, the interpolations with their divider steps,
// the queue drops between de Casteljau levels, and the response handshake.
// ----------------------------------------------------------------------------
module bps_ctrl import bps_pkg::*; #(
   parameter int DIV_STEPS = (COORD_BITS_DEF + FRAC_BITS_DEF + 1) / 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output bps_cmd_type cmd,
   input  bps_sts_type sts
);

   localparam int DCW = $clog2(DIV_STEPS);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_PREP = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_WB   = 3'd4;
   localparam logic [2:0] ST_DROP = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   // interpolation order of the cubic evaluation
   localparam logic [2:0] LERP_LEVEL_ONE_END = 3'd2;
   localparam logic [2:0] LERP_LEVEL_TWO_END = 3'd4;
   localparam logic [2:0] LERP_LAST          = 3'd5;

   logic [2:0]     state_in, state_ff;
   logic [DCW-1:0] div_cnt_in, div_cnt_ff;
   logic [2:0]     lerp_in, lerp_ff;
   logic [1:0]     drop_in, drop_ff;
   logic           out_vld_in, out_vld_ff;

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      lerp_in    = lerp_ff;
      drop_in    = drop_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               lerp_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep   = 1'b1;
            div_cnt_in = DCW'(DIV_STEPS - 1);
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            cmd.div = 1'b1;
            if (div_cnt_ff == '0) begin
               state_in = ST_WB;
            end else begin
               div_cnt_in = div_cnt_ff - DCW'(1);
            end
         end
         ST_WB: begin
            cmd.wb = 1'b1;
            if (!sts.cubic || lerp_ff == LERP_LAST) begin
               state_in = ST_DONE;
            end else begin
               lerp_in = lerp_ff + 3'd1;
               // stale entries sit at the queue head after each level
               priority if (lerp_ff == LERP_LEVEL_ONE_END) begin
                  drop_in  = 2'd0;
                  state_in = ST_DROP;
               end else if (lerp_ff == LERP_LEVEL_TWO_END) begin
                  drop_in  = 2'd1;
                  state_in = ST_DROP;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_DROP: begin
            cmd.drop = 1'b1;
            if (drop_ff == '0) begin
               state_in = ST_MUL;
            end else begin
               drop_in = drop_ff - 2'd1;
            end
         end
         ST_DONE: begin
            if (!out_vld_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign out_vld_in = cmd.emit | (out_vld_ff & ~rsp_ready);
   assign rsp_valid  = out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_cnt_ff <= '0;
         lerp_ff    <= '0;
         drop_ff    <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
         lerp_ff    <= lerp_in;
         drop_ff    <= drop_in;
         out_vld_ff <= out_vld_in;
      end
   end

endmodule

FILE: hw/rtl/bezier_path_stepper_core.sv
// ----------------------------------------------------------------------------
// bezier_path_stepper_core
// Steps along a straight line or cubic bezier path, one point per request.
//
// Usage: each transfer on req_chan is one tick; restart clears the step
// counter first. The counter then advances by one, saturating at step_total,
// and the point at t = count / step_total leaves on rsp_chan together with
// the count used. Registers are written through csr_wr_en / csr_index /
// csr_wdata while no tick is in flight.
// Sequence: every interpolation is a multiply, a divider setup, S = (COORD_BITS +
// FRAC_BITS + 1) / 2 two-bit divider steps (S = 12 by default) and a write-back.
// A straight line takes one interpolation, a cubic six plus three queue shifts.
// A new request is taken only once the point of the last one has been
// emitted into the output register.
// Reset restores the register defaults and clears the counter.
// A stalled response waits in the output register; the next request is
// taken meanwhile, and its result is held back until the first is taken.
// ----------------------------------------------------------------------------
module bezier_path_stepper_core import bps_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   bps_req_if.sink                 req_chan,
   bps_rsp_if.source               rsp_chan,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [REG_BITS-1:0]     csr_wdata
);

   localparam int VAL_BITS  = COORD_BITS + FRAC_BITS;
   localparam int DIV_STEPS = (VAL_BITS + 1) / 2;

   bps_cmd_type cmd;
   bps_sts_type sts;

   bps_ctrl #(.DIV_STEPS(DIV_STEPS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   bps_dp #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_restart (req_chan.restart),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .point_x     (rsp_chan.point_x),
      .point_y     (rsp_chan.point_y),
      .step_index  (rsp_chan.step_index)
   );

   // datapath commands never overlap
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("overlapping datapath commands");

   // a request transfer starts the first multiply right away
   a_start_mul: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> cmd.mul)
      else $error("request transfer not followed by multiply");

   // the output register is never overwritten while a result waits
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("pending response overwritten");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_chan.valid)
      else $error("emitted point not presented");

endmodule
